// File: hw/rtl/avs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_pkg
// Shared constants and controller/datapath interface types for the absolute
// value statistics unit.
// ----------------------------------------------------------------------------
package avs_pkg;

	localparam int unsigned MAX_SAMPLES_DEF = 1024;
	localparam int unsigned DATA_W          = 32;
	localparam int unsigned VAR_W           = 64;
	localparam int unsigned COUNT_OUT_W     = 11;
	localparam int unsigned PADDR_W         = 3;
	localparam int unsigned PDATA_W         = 32;

	localparam logic [0:0] REG_MIN_FLOOR = 1'b0;

	typedef struct packed {
		logic load;
		logic mean_start;
		logic mean_done;
		logic pass_read;
		logic var_start;
		logic finish;
	} avs_cmd_t;

	typedef struct packed {
		logic div_done;
		logic reads_done;
		logic pipe_busy;
	} avs_status_t;

endpackage

// File: hw/rtl/avs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module avs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/avs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module avs_div #(
	parameter int unsigned N = 75,
	parameter int unsigned M = 11
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [M-1:0] divisor,
	output logic [N-1:0] quotient,
	output logic         done
);

	localparam int unsigned CNT_W = $clog2(N + 1);

	logic [N-1:0]     quo_q;
	logic [M-1:0]     rem_q;
	logic [M-1:0]     dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [M:0]       shifted;
	logic             ge;
	logic [M:0]       diff;

	assign shifted = {rem_q, quo_q[N-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(N);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[N-2:0], ge};
			rem_q <= ge ? diff[M-1:0] : shifted[M-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// File: hw/rtl/avs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_datapath
// Run statistics, sample store, squared-deviation pipeline and shared divider.
// ----------------------------------------------------------------------------
module avs_datapath
	import avs_pkg::*;
#(
	parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  avs_cmd_t               cmd,
	output avs_status_t            status,
	input  logic [DATA_W-1:0]      min_floor,
	input  logic [DATA_W-1:0]      sample,
	output logic [DATA_W-1:0]      max_abs,
	output logic [DATA_W-1:0]      min_abs,
	output logic                   min_found,
	output logic [DATA_W-1:0]      mean_abs,
	output logic [VAR_W-1:0]       variance,
	output logic [COUNT_OUT_W-1:0] sample_count,
	output logic                   overflow,
	output logic                   done
);

	localparam int unsigned AW    = $clog2(MAX_SAMPLES);
	localparam int unsigned CW    = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned SUM_W = DATA_W + CW;
	localparam int unsigned ACC_W = 2 * DATA_W + CW;
	localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_SAMPLES);

	logic [DATA_W-1:0] running_max_q;
	logic [DATA_W-1:0] running_min_q;
	logic              min_seen_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CW-1:0]     count_q;
	logic              dropped_q;
	logic [DATA_W-1:0] mean_q;
	logic [CW-1:0]     rd_addr_q;
	logic              rd_v_s1;
	logic [DATA_W-1:0] d_s2;
	logic              d_v_s2;
	logic [2*DATA_W-1:0] sq_s3;
	logic              sq_v_s3;
	logic [ACC_W-1:0]  acc_q;

	logic [DATA_W-1:0] max_abs_q;
	logic [DATA_W-1:0] min_abs_q;
	logic              min_found_q;
	logic [DATA_W-1:0] mean_abs_q;
	logic [VAR_W-1:0]  variance_q;
	logic [COUNT_OUT_W-1:0] sample_count_q;
	logic              overflow_q;
	logic              done_q;

	logic [DATA_W-1:0] mag;
	logic              has_room;
	logic              store_we;
	logic [DATA_W-1:0] rd_data;
	logic [ACC_W-1:0]  div_dividend;
	logic [ACC_W-1:0]  div_quotient;
	logic              div_done;
	logic [VAR_W-1:0]  var_sat;
	logic [CW+COUNT_OUT_W-1:0] count_ext;

	assign mag       = sample[DATA_W-1] ? (DATA_W'(0) - sample) : sample;
	assign has_room  = count_q < COUNT_MAX;
	assign store_we  = cmd.load && has_room;
	assign count_ext = {{COUNT_OUT_W{1'b0}}, count_q};

	assign div_dividend = cmd.var_start ? acc_q : ACC_W'(sum_q);
	assign var_sat      = (|div_quotient[ACC_W-1:VAR_W]) ? '1 : div_quotient[VAR_W-1:0];

	avs_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[AW-1:0]),
		.wdata (mag),
		.re    (cmd.pass_read),
		.raddr (rd_addr_q[AW-1:0]),
		.rdata (rd_data)
	);

	avs_div #(
		.N (ACC_W),
		.M (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mean_start || cmd.var_start),
		.dividend (div_dividend),
		.divisor  (count_q),
		.quotient (div_quotient),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_max_q <= '0;
			running_min_q <= '1;
			min_seen_q    <= 1'b0;
			sum_q         <= '0;
			count_q       <= '0;
			dropped_q     <= 1'b0;
		end else if (cmd.finish) begin
			running_max_q <= '0;
			running_min_q <= '1;
			min_seen_q    <= 1'b0;
			sum_q         <= '0;
			count_q       <= '0;
			dropped_q     <= 1'b0;
		end else if (cmd.load) begin
			if (has_room) begin
				count_q <= count_q + CW'(1);
				sum_q   <= sum_q + SUM_W'(mag);
				if (mag > running_max_q) begin
					running_max_q <= mag;
				end
				if (mag > min_floor && mag < running_min_q) begin
					running_min_q <= mag;
					min_seen_q    <= 1'b1;
				end
			end else begin
				dropped_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
			rd_v_s1   <= 1'b0;
			d_v_s2    <= 1'b0;
			sq_v_s3   <= 1'b0;
		end else begin
			if (cmd.mean_done || cmd.finish) begin
				rd_addr_q <= '0;
			end else if (cmd.pass_read) begin
				rd_addr_q <= rd_addr_q + CW'(1);
			end
			rd_v_s1 <= cmd.pass_read;
			d_v_s2  <= rd_v_s1;
			sq_v_s3 <= d_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mean_done) begin
			mean_q <= div_quotient[DATA_W-1:0];
		end
		d_s2  <= (rd_data >= mean_q) ? (rd_data - mean_q) : (mean_q - rd_data);
		sq_s3 <= d_s2 * d_s2;
		if (cmd.mean_done) begin
			acc_q <= '0;
		end else if (sq_v_s3) begin
			acc_q <= acc_q + ACC_W'(sq_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			max_abs_q      <= running_max_q;
			min_abs_q      <= min_seen_q ? running_min_q : '0;
			min_found_q    <= min_seen_q;
			mean_abs_q     <= mean_q;
			variance_q     <= var_sat;
			sample_count_q <= count_ext[COUNT_OUT_W-1:0];
			overflow_q     <= dropped_q;
		end
	end

	assign status.div_done   = div_done;
	assign status.reads_done = rd_addr_q == count_q;
	assign status.pipe_busy  = rd_v_s1 || d_v_s2 || sq_v_s3;

	assign max_abs      = max_abs_q;
	assign min_abs      = min_abs_q;
	assign min_found    = min_found_q;
	assign mean_abs     = mean_abs_q;
	assign variance     = variance_q;
	assign sample_count = sample_count_q;
	assign overflow     = overflow_q;
	assign done         = done_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_MAX)
		else $error("Stored count exceeds the store depth.");

	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_addr_q <= count_q)
		else $error("Variance pass reads beyond the stored samples.");

	a_drop_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && !has_room && !cmd.finish |=> dropped_q)
		else $error("A sample dropped on a full store did not set the overflow flag.");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> done_q && count_q == '0 && !min_seen_q)
		else $error("Result transfer did not clear the run state.");

endmodule

// File: hw/rtl/avs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avs_ctrl
// Sequencer for sample loading, mean division, variance pass and result.
// ----------------------------------------------------------------------------
module avs_ctrl
	import avs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        last,
	input  avs_status_t status,
	output avs_cmd_t    cmd,
	output logic        busy
);

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_MEAN_GO   = 3'd1;
	localparam logic [2:0] S_MEAN_WAIT = 3'd2;
	localparam logic [2:0] S_PASS      = 3'd3;
	localparam logic [2:0] S_VAR_WAIT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
				if (start && last) begin
					state_d = S_MEAN_GO;
				end
			end
			S_MEAN_GO: begin
				cmd.mean_start = 1'b1;
				state_d        = S_MEAN_WAIT;
			end
			S_MEAN_WAIT: begin
				if (status.div_done) begin
					cmd.mean_done = 1'b1;
					state_d       = S_PASS;
				end
			end
			S_PASS: begin
				cmd.pass_read = !status.reads_done;
				if (status.reads_done && !status.pipe_busy) begin
					cmd.var_start = 1'b1;
					state_d       = S_VAR_WAIT;
				end
			end
			S_VAR_WAIT: begin
				if (status.div_done) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

	a_var_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.var_start |-> status.reads_done && !status.pipe_busy)
		else $error("Variance division started before the pass drained.");

	a_last_starts_mean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && last |=> state_q == S_MEAN_GO)
		else $error("Last transfer did not start the mean division.");

endmodule

// File: hw/rtl/abs_value_statistics_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abs_value_statistics_unit
// Max, min above a floor, mean and variance of absolute sample values.
//
// A sample transfer happens on a rising edge with start high and busy low;
// last marks the final sample of a run. Samples load at one per cycle while
// busy stays low. Each stored absolute value goes into a two-port store
// of MAX_SAMPLES entries; samples beyond that depth are dropped and flagged.
// After the last sample, busy rises and the unit divides the sum by the
// count, reads the store once to sum squared deviations, and divides again.
// Both divisions run on one shared divider at one bit per cycle over
// ACC_W = 64 + clog2(MAX_SAMPLES + 1) bits (75 by default).
// The result is shown for one cycle with done high; the receiver cannot
// stall it. busy falls as done rises, and the next run may start then.
// Reset clears the run state and min_floor; the store needs no clearing.
// min_floor is written over the APB port at byte address 0.
// ----------------------------------------------------------------------------
module abs_value_statistics_unit
	import avs_pkg::*;
#(
	parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [PDATA_W-1:0]     pwdata,
	output logic [PDATA_W-1:0]     prdata,
	output logic                   pready,
	input  logic                   start,
	output logic                   busy,
	input  logic [DATA_W-1:0]      sample,
	input  logic                   last,
	output logic                   done,
	output logic [DATA_W-1:0]      max_abs,
	output logic [DATA_W-1:0]      min_abs,
	output logic                   min_found,
	output logic [DATA_W-1:0]      mean_abs,
	output logic [VAR_W-1:0]       variance,
	output logic [COUNT_OUT_W-1:0] sample_count,
	output logic                   overflow
);

	logic [DATA_W-1:0] min_floor_q;
	logic              reg_sel;
	avs_cmd_t          cmd;
	avs_status_t       status;

	assign reg_sel = paddr[PADDR_W-1:2] == REG_MIN_FLOOR;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? min_floor_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_floor_q <= '0;
		end else if (psel && penable && pwrite && reg_sel) begin
			min_floor_q <= pwdata;
		end
	end

	avs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	avs_datapath #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.min_floor    (min_floor_q),
		.sample       (sample),
		.max_abs      (max_abs),
		.min_abs      (min_abs),
		.min_found    (min_found),
		.mean_abs     (mean_abs),
		.variance     (variance),
		.sample_count (sample_count),
		.overflow     (overflow),
		.done         (done)
	);

endmodule

// File: tb/abs_value_statistics_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abs_value_statistics_checker
// Watches the sample, result and register channels of the absolute value
// statistics unit. It keeps its own copy of the run state and of min_floor,
// works out the statistics expected at the end of each run, and compares each
// result transfer field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module abs_value_statistics_checker
	import avs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic                   pready,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [PDATA_W-1:0]     pwdata,
	input  logic                   start,
	input  logic                   busy,
	input  logic [DATA_W-1:0]      sample,
	input  logic                   last,
	input  logic                   done,
	input  logic [DATA_W-1:0]      max_abs,
	input  logic [DATA_W-1:0]      min_abs,
	input  logic                   min_found,
	input  logic [DATA_W-1:0]      mean_abs,
	input  logic [VAR_W-1:0]       variance,
	input  logic [COUNT_OUT_W-1:0] sample_count,
	input  logic                   overflow,
	output int unsigned            error_count,
	output int unsigned            pending_count
);

	typedef struct packed {
		logic [DATA_W-1:0]      peak;
		logic [DATA_W-1:0]      trough;
		logic                   trough_valid;
		logic [DATA_W-1:0]      mean;
		logic [VAR_W-1:0]       spread;
		logic [COUNT_OUT_W-1:0] count;
		logic                   dropped;
	} run_stats_t;

	run_stats_t        run_stats_q[$];
	run_stats_t        want;
	logic [DATA_W-1:0] abs_mem [MAX_SAMPLES_DEF];
	logic [DATA_W-1:0] floor_reg;
	logic [DATA_W-1:0] magnitude;
	logic [DATA_W-1:0] peak;
	logic [DATA_W-1:0] trough;
	logic [DATA_W-1:0] avg;
	logic              trough_valid;
	logic              samples_dropped;
	logic [41:0]       mag_sum;
	int unsigned       fill;
	logic [63:0]       dev;
	logic [127:0]      dev_sum;
	logic [127:0]      spread_quot;

	initial begin
		error_count = 0;
		pending_count = 0;
	end

	task automatic check_field(input string name, input logic [63:0] exp_val,
			input logic [63:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h",
				$time, name, exp_val, act_val);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			floor_reg = '0;
			peak = '0;
			trough = '1;
			trough_valid = 1'b0;
			mag_sum = '0;
			fill = 0;
			samples_dropped = 1'b0;
			run_stats_q.delete();
		end else begin
			if (done) begin
				if (run_stats_q.size() == 0) begin
					$display("%0t ns: result transfer with none expected, actual max %0h min %0h mean %0h var %0h count %0d",
						$time, max_abs, min_abs, mean_abs, variance, sample_count);
					error_count++;
				end else begin
					want = run_stats_q.pop_front();
					check_field("max_abs", 64'(want.peak), 64'(max_abs));
					check_field("min_abs", 64'(want.trough), 64'(min_abs));
					check_field("min_found", 64'(want.trough_valid), 64'(min_found));
					check_field("mean_abs", 64'(want.mean), 64'(mean_abs));
					check_field("variance", want.spread, variance);
					check_field("sample_count", 64'(want.count), 64'(sample_count));
					check_field("overflow", 64'(want.dropped), 64'(overflow));
				end
			end

			if (psel && penable && pwrite && pready
					&& paddr[PADDR_W-1:2] == REG_MIN_FLOOR)
				floor_reg = pwdata[DATA_W-1:0];

			if (start && !busy) begin
				magnitude = sample[DATA_W-1] ? -sample : sample;
				if (fill < MAX_SAMPLES_DEF) begin
					abs_mem[fill] = magnitude;
					fill++;
					if (magnitude > peak)
						peak = magnitude;
					if (magnitude > floor_reg && magnitude < trough) begin
						trough = magnitude;
						trough_valid = 1'b1;
					end
					mag_sum += 42'(magnitude);
				end else begin
					samples_dropped = 1'b1;
				end

				if (last) begin
					avg = (fill != 0) ? DATA_W'(mag_sum / fill) : '0;
					dev_sum = '0;
					for (int i = 0; i < fill; i++) begin
						dev = (abs_mem[i] >= avg) ? 64'(abs_mem[i] - avg)
							: 64'(avg - abs_mem[i]);
						dev_sum += 128'(dev * dev);
					end
					spread_quot = (fill != 0) ? dev_sum / fill : '0;
					want.peak = peak;
					want.trough = trough_valid ? trough : '0;
					want.trough_valid = trough_valid;
					want.mean = avg;
					want.spread = (spread_quot[127:64] != '0) ? '1 : spread_quot[63:0];
					want.count = COUNT_OUT_W'(fill);
					want.dropped = samples_dropped;
					run_stats_q.push_back(want);
					peak = '0;
					trough = '1;
					trough_valid = 1'b0;
					mag_sum = '0;
					fill = 0;
					samples_dropped = 1'b0;
				end
			end
		end
		pending_count = run_stats_q.size();
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the absolute value statistics unit.
// Directed runs cover extreme samples, the floor at its limits, a sample that
// sets both max and min, and runs with nothing above the floor. Random runs of
// mixed length and content follow, with the floor changed between runs, and
// then a run that fills the store and overflows it by two samples.
// ----------------------------------------------------------------------------
module testbench;
	import avs_pkg::*;

	localparam int unsigned STALL_LIMIT  = 10000;
	localparam int unsigned END_WAIT     = 200;
	localparam int unsigned RANDOM_ITEMS = 200;
	localparam int unsigned OVER_ITEMS   = 2;
	localparam logic [0:0]  REG_SPARE    = 1'b1;

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_W-1:0]     paddr;
	logic [PDATA_W-1:0]     pwdata;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;
	logic                   start;
	logic                   busy;
	logic [DATA_W-1:0]      sample;
	logic                   last;
	logic                   done;
	logic [DATA_W-1:0]      max_abs;
	logic [DATA_W-1:0]      min_abs;
	logic                   min_found;
	logic [DATA_W-1:0]      mean_abs;
	logic [VAR_W-1:0]       variance;
	logic [COUNT_OUT_W-1:0] sample_count;
	logic                   overflow;
	int unsigned            error_count;
	int unsigned            pending_count;
	int unsigned            stall_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	abs_value_statistics_unit i_dut (.*);

	abs_value_statistics_checker i_checker (.*);

	initial stall_cycles = 0;

	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	function automatic logic [DATA_W-1:0] pick_sample();
		logic [DATA_W-1:0] mag;
		case ($urandom_range(0, 9)) inside
			0: begin
				case ($urandom_range(0, 4))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					3: return 32'h0000_0001;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			[1:2]: begin
				mag = $urandom_range(0, 32'h0000_FFFF);
				return $urandom_range(0, 1) ? -mag : mag;
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic int unsigned pick_gap(input bit steady);
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (steady || roll < 12)
			return 0;
		if (roll < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Drives one sample and holds it until the transfer; then, for a nonzero
	// gap, drops start and idles with noise on the payload.
	task automatic send_sample(input logic [DATA_W-1:0] value, input logic fin,
			input int unsigned gap);
		@(negedge clk);
		start <= 1'b1;
		sample <= value;
		last <= fin;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (gap != 0) begin
			@(negedge clk);
			start <= 1'b0;
			sample <= $urandom;
			last <= $urandom_range(0, 1);
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Drops start so that a held sample is not taken again, then waits until
	// the unit is idle and every expected result has arrived.
	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_count != 0 || busy)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] index, input logic [PDATA_W-1:0] value);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({index, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_run(input int unsigned len, input bit steady);
		for (int unsigned k = 0; k < len; k++)
			send_sample(pick_sample(), k == len - 1, pick_gap(steady));
	endtask

	initial begin
		int unsigned sent;
		int unsigned len;
		logic [PDATA_W-1:0] floor_val;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		sample = '0;
		last = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_MIN_FLOOR, 32'h0000_0000);
		send_sample(32'h0000_0000, 1'b1, 0);
		send_sample(32'h8000_0000, 1'b0, 0);
		send_sample(32'h7FFF_FFFF, 1'b0, 1);
		send_sample(32'hFFFF_FFFF, 1'b0, 0);
		send_sample(32'h0000_0001, 1'b1, 2);
		send_sample(32'h0001_2345, 1'b1, 0);
		send_sample(32'h0000_0007, 1'b0, 0);
		send_sample(32'h0000_0003, 1'b0, 0);
		send_sample(32'hFFFF_FFF9, 1'b0, 3);
		send_sample(32'h0000_0003, 1'b1, 0);
		write_reg(REG_MIN_FLOOR, 32'h8000_0000);
		send_sample(32'h8000_0000, 1'b0, 0);
		send_sample(32'h7FFF_FFFF, 1'b1, 0);
		write_reg(REG_MIN_FLOOR, 32'h7FFF_FFFF);
		send_sample(32'h8000_0000, 1'b0, 0);
		send_sample(32'h7FFF_FFFF, 1'b1, 0);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		write_reg(REG_MIN_FLOOR, 32'h0000_0064);
		send_sample(32'h0000_0064, 1'b0, 0);
		send_sample(32'h0000_0065, 1'b0, 0);
		send_sample(32'hFFFF_FF9C, 1'b0, 0);
		send_sample(32'hFFFF_FF9B, 1'b1, 0);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 3))
					0: floor_val = 32'h0000_0000;
					1: floor_val = 32'h8000_0000;
					2: floor_val = $urandom_range(0, 32'h0000_FFFF);
					default: floor_val = $urandom_range(0, 32'h8000_0000);
				endcase
				write_reg(REG_MIN_FLOOR, floor_val);
			end
			if ($urandom_range(0, 15) == 0)
				write_reg(REG_SPARE, $urandom);
			len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12)
				: $urandom_range(13, 80);
			random_run(len, $urandom_range(0, 3) == 0);
			sent += len;
		end

		write_reg(REG_MIN_FLOOR, 32'h0000_0000);
		random_run(MAX_SAMPLES_DEF + OVER_ITEMS, $urandom_range(0, 1));

		wait_idle();
		repeat (END_WAIT) @(posedge clk);
		if (error_count == 0 && pending_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/avs_pkg.sv
hw/rtl/avs_ram.sv
hw/rtl/avs_div.sv
hw/rtl/avs_datapath.sv
hw/rtl/avs_ctrl.sv
hw/rtl/abs_value_statistics_unit.sv
tb/abs_value_statistics_checker.sv
tb/testbench.sv
